// File: sv/sha256_pkg.sv
// Package: SHA-256 constants, round function helpers and shared types.
`timescale 1ns / 1ps
package sha256_pkg;

    localparam int unsigned QueueDepth = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUNDS,
        ST_PAD,
        ST_EMIT
    } back_state_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
            32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
            32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
            32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
            32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
            32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
            32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
            32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
            32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        round_k = k[idx];
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        init_hash = h[idx];
    endfunction

    localparam logic [7:0] PadByte = 8'h80;

endpackage

// File: sv/sha256_if.sv
// Interfaces: valid/ready channels for input bytes and digest words.
`timescale 1ns / 1ps
interface sha256_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha256_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/sha256_front.sv
// Front end: input queue that takes transactions and drops idle ones.
`timescale 1ns / 1ps
module sha256_front (
    input  logic                  clk,
    input  logic                  rst_n,
    sha256_in_if.sink             in_ch,
    output logic                  q_valid,
    output sha256_pkg::in_item_t  q_item,
    input  logic                  q_pop
);
    localparam int unsigned AW = $clog2(sha256_pkg::QueueDepth);

    sha256_pkg::in_item_t mem_reg [sha256_pkg::QueueDepth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          push;

    assign in_ch.ready = (cnt_reg != (AW+1)'(sha256_pkg::QueueDepth));
    assign push = in_ch.valid && in_ch.ready && (in_ch.has_byte || in_ch.end_of_message);
    assign q_valid = (cnt_reg != '0);
    assign q_item = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= '{in_ch.data_byte, in_ch.has_byte, in_ch.end_of_message};
        end
    end
endmodule

// File: sv/sha256_back.sv
// Back end: byte packing, padding, 64-round compression and digest output.
`timescale 1ns / 1ps
module sha256_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  sha256_pkg::in_item_t  q_item,
    output logic                  q_pop,
    sha256_out_if.source          out_ch
);
    typedef sha256_pkg::word_t word_t;

    sha256_pkg::back_state_t state_reg, state_next;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_reg [16];
    logic [63:0] bits_reg;
    logic [5:0]  slot_reg;
    logic [5:0]  round_reg;
    logic        fin_reg;
    logic        second_reg;
    logic        len_done_reg;
    logic [2:0]  idx_reg;
    logic        ov_reg;

    logic        take, start_item, rounds_done, len_fit;
    word_t       t1, t2, s0, s1, w_new;
    logic [5:0]  slot_inc;
    logic [3:0]  wi;
    logic [1:0]  bi;

    assign slot_inc = slot_reg + 6'd1;
    assign wi = slot_reg[5:2];
    assign bi = slot_reg[1:0];
    assign start_item = (state_reg == sha256_pkg::ST_IDLE) && q_valid;
    assign q_pop = start_item;
    assign rounds_done = (state_reg == sha256_pkg::ST_ROUNDS) && (round_reg == 6'd63);
    assign take = out_ch.valid && out_ch.ready;
    // length goes into this pad block
    assign len_fit = second_reg || (slot_reg < 6'd56);

    always_comb
    begin
        s1 = sha256_pkg::rotr(v_reg[4], 6) ^ sha256_pkg::rotr(v_reg[4], 11)
           ^ sha256_pkg::rotr(v_reg[4], 25);
        s0 = sha256_pkg::rotr(v_reg[0], 2) ^ sha256_pkg::rotr(v_reg[0], 13)
           ^ sha256_pkg::rotr(v_reg[0], 22);
        t1 = v_reg[7] + s1 + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::round_k(round_reg) + w_reg[0];
        t2 = s0 + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + w_reg[9]
              + (sha256_pkg::rotr(w_reg[1], 7) ^ sha256_pkg::rotr(w_reg[1], 18)
                 ^ (w_reg[1] >> 3))
              + (sha256_pkg::rotr(w_reg[14], 17) ^ sha256_pkg::rotr(w_reg[14], 19)
                 ^ (w_reg[14] >> 10));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                if (start_item)
                begin
                    if (q_item.has_byte && slot_reg == 6'd63)
                    begin
                        state_next = sha256_pkg::ST_ROUNDS;
                    end
                    else if (q_item.end_of_message)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_ROUNDS:
            begin
                if (rounds_done)
                begin
                    if (!fin_reg)
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                    end
                    else if (len_done_reg)
                    begin
                        state_next = sha256_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                state_next = sha256_pkg::ST_ROUNDS;
            end
            sha256_pkg::ST_EMIT:
            begin
                if (take && idx_reg == 3'd7)
                begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_ch.valid       = ov_reg;
        out_ch.digest_word = h_reg[idx_reg];
        out_ch.word_index  = idx_reg;
        out_ch.last_word   = (idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sha256_pkg::ST_IDLE;
            bits_reg     <= '0;
            slot_reg     <= '0;
            round_reg    <= '0;
            fin_reg      <= 1'b0;
            second_reg   <= 1'b0;
            len_done_reg <= 1'b0;
            idx_reg      <= '0;
            ov_reg       <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sha256_pkg::ST_IDLE:
                begin
                    if (start_item)
                    begin
                        fin_reg      <= q_item.end_of_message;
                        second_reg   <= 1'b0;
                        len_done_reg <= 1'b0;
                        if (q_item.has_byte)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                            slot_reg <= slot_inc;
                        end
                    end
                end
                sha256_pkg::ST_ROUNDS:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (rounds_done)
                    begin
                        h_reg[0] <= h_reg[0] + t1 + t2;
                        h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                        for (int i = 1; i < 8; i++)
                        begin
                            if (i != 4)
                            begin
                                h_reg[i] <= h_reg[i] + v_reg[i-1];
                            end
                        end
                        if (fin_reg && len_done_reg)
                        begin
                            ov_reg  <= 1'b1;
                            idx_reg <= '0;
                        end
                    end
                end
                sha256_pkg::ST_PAD:
                begin
                    if (len_fit)
                    begin
                        len_done_reg <= 1'b1;
                    end
                    else
                    begin
                        second_reg <= 1'b1;
                    end
                end
                sha256_pkg::ST_EMIT:
                begin
                    if (take)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            ov_reg   <= 1'b0;
                            bits_reg <= '0;
                            slot_reg <= '0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= sha256_pkg::init_hash(3'(i));
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // block words: byte writes, padding fill, then a sliding schedule window
    always_ff @(posedge clk)
    begin
        if (start_item && q_item.has_byte)
        begin
            w_reg[wi][8*(3-bi) +: 8] <= q_item.data_byte;
        end
        else if (state_reg == sha256_pkg::ST_PAD)
        begin
            for (int j = 0; j < 16; j++)
            begin
                if (len_fit && j >= 14)
                begin
                    w_reg[j] <= (j == 14) ? bits_reg[63:32] : bits_reg[31:0];
                end
                else
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (6'(4*j + b) == slot_reg && !second_reg)
                        begin
                            w_reg[j][8*(3-b) +: 8] <= sha256_pkg::PadByte;
                        end
                        else if (6'(4*j + b) > slot_reg || second_reg)
                        begin
                            w_reg[j][8*(3-b) +: 8] <= 8'h00;
                        end
                    end
                end
            end
        end
        else if (state_reg == sha256_pkg::ST_ROUNDS)
        begin
            for (int j = 0; j < 15; j++)
            begin
                w_reg[j] <= w_reg[j+1];
            end
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sha256_pkg::ST_ROUNDS)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (state_reg == sha256_pkg::ST_PAD ||
                 (start_item && q_item.has_byte && slot_reg == 6'd63))
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
    end
endmodule

// File: sv/sha256_byte_stream_hasher.sv
// Top level: SHA-256 hasher over a byte stream with digest word output.
`timescale 1ns / 1ps
// Bytes enter a 4-entry queue and are packed into 512-bit blocks by the back
// end, which takes a byte from the queue while idle. The 64th byte of a block
// starts the compression core, which runs 64 rounds (one round per cycle)
// before the next byte is taken from the queue. End of message adds a padding
// step and 64 rounds, or a second padding step and 64 more rounds if the length
// does not fit after the last byte, then the eight digest words go out one per
// accepted transaction. The queue keeps taking transactions while the core runs until it is full.
module sha256_byte_stream_hasher (
    input  logic         clk,
    input  logic         rst_n,
    sha256_in_if.sink    in_ch,
    sha256_out_if.source out_ch
);
    logic                 q_valid;
    logic                 q_pop;
    sha256_pkg::in_item_t q_item;

    sha256_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    sha256_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );
endmodule

// File: tb/sv/testbench.sv
// Testbench for the SHA-256 byte stream hasher: directed and random messages.
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        sha256_pkg::word_t digest_word;
        logic [2:0]        word_index;
        logic              last_word;
    } digest_rec_t;

    localparam sha256_pkg::word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam sha256_pkg::word_t InitH [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    logic clk;
    logic rst_n;

    sha256_in_if  in_ch ();
    sha256_out_if out_ch ();

    sha256_byte_stream_hasher DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sha256_pkg::word_t hash_state [8];
    sha256_pkg::word_t msg_block [16];
    logic [63:0]       bit_count;
    int unsigned       block_pos;
    digest_rec_t       pending_words [$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold;
    int          mismatches;

    function automatic sha256_pkg::word_t ror(sha256_pkg::word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        sha256_pkg::word_t w [64];
        sha256_pkg::word_t v [8];
        sha256_pkg::word_t t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = msg_block[t];
        for (int t = 16; t < 64; t++)
        begin
            s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        v = hash_state;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w[r];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    function automatic void place_byte(int unsigned pos, logic [7:0] b);
        int unsigned sh;
        sh = (3 - (pos % 4)) * 8;
        msg_block[pos / 4] = (msg_block[pos / 4] & ~(32'hff << sh))
                           | (sha256_pkg::word_t'(b) << sh);
    endfunction

    task automatic predict_digest(logic [7:0] b, logic hb, logic eom);
        digest_rec_t rec;
        if (hb)
        begin
            place_byte(block_pos, b);
            bit_count += 8;
            block_pos = (block_pos + 1) % 64;
            if (block_pos == 0)
                compress_block();
        end
        if (eom)
        begin
            place_byte(block_pos, sha256_pkg::PadByte);
            for (int s = block_pos + 1; s < 64; s++)
                place_byte(s, 8'h00);
            if (block_pos >= 56)
            begin
                compress_block();
                for (int i = 0; i < 16; i++)
                    msg_block[i] = '0;
            end
            msg_block[14] = bit_count[63:32];
            msg_block[15] = bit_count[31:0];
            compress_block();
            for (int k = 0; k < 8; k++)
            begin
                rec.digest_word = hash_state[k];
                rec.word_index  = 3'(k);
                rec.last_word   = (k == 7);
                pending_words.insert(pending_words.size(), rec);
            end
            hash_state = InitH;
            bit_count = '0;
            block_pos = 0;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_item(logic [7:0] b, logic hb, logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.has_byte       <= hb;
        in_ch.end_of_message <= eom;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_digest(b, hb, eom);
    endtask

    task automatic send_message(int unsigned len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, (i == len - 1));
        if (len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls plus optional long hold-off
    always @(posedge clk)
    begin
        if (recv_hold != 0)
        begin
            out_ch.ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        digest_rec_t exp_rec;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h", out_ch.digest_word);
            end
            else
            begin
                exp_rec = pending_words.pop_front();
                if (out_ch.digest_word !== exp_rec.digest_word
                    || out_ch.word_index !== exp_rec.word_index
                    || out_ch.last_word !== exp_rec.last_word)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h/%0d/%b got %h/%0d/%b",
                            exp_rec.digest_word, exp_rec.word_index, exp_rec.last_word,
                            out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                end
            end
        end
    end

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);               // empty message
        send_item(8'hff, 1'b0, 1'b0);               // idle item
        send_item(8'h61, 1'b1, 1'b0);               // "abc"
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'haa, 1'b0, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);               // end without byte
        wait_drained();
    endtask

    task automatic test_lengths();
        send_message(56);                           // long tail
        send_message(64);                           // full block then pad
        wait_drained();
    endtask

    task automatic test_random(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(8'($urandom), 1'($urandom), 1'($urandom));
                sent++;
            end
            else
            begin
                len = $urandom_range(12);
                if (len > n_items - sent)
                    len = n_items - sent;
                send_message(len);
                sent += (len == 0) ? 1 : len;
            end
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        recv_hold = 400;
        send_message(3);
        send_message(0);
        send_message(12);
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
        recv_hold = 0;
        mismatches = 0;
        hash_state = InitH;
        for (int i = 0; i < 16; i++)
            msg_block[i] = '0;
        bit_count = '0;
        block_pos = 0;
        send_idle_pct = 22;
        recv_idle_pct = 61;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_lengths();
        test_random(12);
        send_idle_pct = 61;
        recv_idle_pct = 22;
        test_backpressure();
        test_random(12);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(12);
        repeat (300) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
